@@ hw/rtl/cqg_pkg.sv @@
package cqg_pkg;

  localparam int MAX_PARTS        = 256;
  localparam int MAX_REF_VERTICES = 1024;
  localparam int MAX_ENTRIES      = 2048;

  localparam int CMD_W    = 3;
  localparam int VERTEX_W = 10;
  localparam int PART_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int STATUS_W = 2;
  localparam int ADDED_W  = 2;
  localparam int COUNT_W  = 12;
  localparam int CFG_W    = 9;

  localparam logic [CMD_W-1:0] CMD_ADD_EDGE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_PART     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_REF       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_OFFSET   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_NEIGHBOR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREAD,
    S_CHECK,
    S_ROT_READ,
    S_SRCH_INIT,
    S_SRCH_SET,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_ROT_INC,
    S_NREAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       rotate;
    logic [1:0] inc;
  } ring_ctrl_t;

endpackage

@@ hw/rtl/cqg_cell.sv @@
module cqg_cell #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         clear,
  input  logic         rotate,
  input  logic [W-1:0] din,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= '0;
    end else if (rotate) begin
      q <= din;
    end
  end

endmodule

@@ hw/rtl/cqg_offset_ring.sv @@
module cqg_offset_ring #(
  parameter int CELLS = 257,
  parameter int W     = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  cqg_pkg::ring_ctrl_t ctrl,
  output logic [W-1:0]        tap
);

  logic [W-1:0] q   [CELLS];
  logic [W-1:0] din [CELLS];

  always_comb begin
    for (int i = 0; i < CELLS - 1; i++) begin
      din[i] = q[i+1];
    end
    din[CELLS-1] = q[0] + W'(ctrl.inc);
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cqg_cell #(.W(W)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .clear  (ctrl.clear),
      .rotate (ctrl.rotate),
      .din    (din[i]),
      .q      (q[i])
    );
  end

  assign tap = q[0];

endmodule

@@ hw/rtl/csr_quotient_graph_builder_top.sv @@
// channel   | handshake              | payload
// cfg       | cfg_we                 | cfg_wdata (num_parts)
// in        | in_valid / in_stall    | command vertex_a vertex_b part_value read_index
// out       | out_valid / out_stall  | status directions_added edge_entries read_value
// One request at a time; the offset ring turns once to read offsets and, when entries are
// added, once more to bump them. List search sets then compares each entry; store shift
// reads then writes each moved entry. Reset and clear empty the ring at once.
// A stalled result holds in the output register; the next request is taken meanwhile.
module csr_quotient_graph_builder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cqg_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cqg_pkg::CMD_W-1:0]     command,
  input  logic [cqg_pkg::VERTEX_W-1:0]  vertex_a,
  input  logic [cqg_pkg::VERTEX_W-1:0]  vertex_b,
  input  logic [cqg_pkg::PART_W-1:0]    part_value,
  input  logic [cqg_pkg::INDEX_W-1:0]   read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cqg_pkg::STATUS_W-1:0]  status,
  output logic [cqg_pkg::ADDED_W-1:0]   directions_added,
  output logic [cqg_pkg::COUNT_W-1:0]   edge_entries,
  output logic [cqg_pkg::COUNT_W-1:0]   read_value
);

  localparam int MAX_PARTS        = cqg_pkg::MAX_PARTS;
  localparam int MAX_REF_VERTICES = cqg_pkg::MAX_REF_VERTICES;
  localparam int MAX_ENTRIES      = cqg_pkg::MAX_ENTRIES;

  localparam int CELLS = MAX_PARTS + 1;
  localparam int PW    = $clog2(CELLS);
  localparam int EW    = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int RW    = $clog2(MAX_REF_VERTICES);
  localparam int NW    = $clog2(MAX_PARTS);

  cqg_pkg::state_t     state, state_next;
  cqg_pkg::ring_ctrl_t ring;

  logic [cqg_pkg::CFG_W-1:0]    num_parts;
  logic [PW-1:0]                np;
  logic [EW-1:0]                total;
  logic [cqg_pkg::CMD_W-1:0]    cmd;
  logic [cqg_pkg::VERTEX_W-1:0] va, vb;
  logic [PW-1:0]                idx;
  logic [EW-1:0]                tap;
  logic [EW-1:0]                lo_a, hi_a, lo_b, hi_b;
  logic [EW-1:0]                k, kend, ins_pos;
  logic                         found_ab, found_ba, pass_ba, ins_ba;
  logic [cqg_pkg::STATUS_W-1:0] res_status;
  logic [cqg_pkg::STATUS_W-1:0] in_status;
  logic [cqg_pkg::ADDED_W-1:0]  res_added;
  logic [cqg_pkg::COUNT_W-1:0]  res_read;
  logic [cqg_pkg::INDEX_W-1:0]  ri;

  logic [NW-1:0] nb_mem [MAX_ENTRIES];
  logic [NW-1:0] nb_q;
  logic [AW-1:0] nb_raddr, nb_waddr;
  logic [NW-1:0] nb_wdata;
  logic          nb_we;

  logic [cqg_pkg::PART_W-1:0] pt_mem [MAX_REF_VERTICES];
  logic [cqg_pkg::PART_W-1:0] pa_q, pb_q;

  logic in_acc, out_load, rot_last, need_ab, need_ba, fits, match, srch_end;
  logic bad_ref, bad_ab, bad_off, bad_nb;
  logic [1:0]    need;
  logic [NW-1:0] srch_to;
  logic [EW-1:0] ba_total, ba_pos;

  always_comb begin
    if (num_parts == '0) begin
      np = PW'(1);
    end else if (32'(num_parts) > MAX_PARTS) begin
      np = PW'(MAX_PARTS);
    end else begin
      np = PW'(num_parts);
    end
  end

  assign in_stall = (state != cqg_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == cqg_pkg::S_DONE) && (!out_valid || !out_stall);
  assign rot_last = (32'(idx) == CELLS - 1);

  assign bad_ref = (32'(vertex_a) >= MAX_REF_VERTICES) || (32'(vertex_b) >= MAX_REF_VERTICES);
  assign bad_ab  = (32'(va) >= 32'(np)) || (32'(vb) >= 32'(np));
  assign bad_off = (32'(read_index) > 32'(np));
  assign bad_nb  = (32'(read_index) >= 32'(total)) || (32'(read_index) >= MAX_ENTRIES);

  assign need_ab  = !found_ab;
  assign need_ba  = (va != vb) && !found_ba;
  assign need     = {1'b0, need_ab} + {1'b0, need_ba};
  assign fits     = (32'(total) + 32'(need)) <= MAX_ENTRIES;
  assign srch_to  = pass_ba ? NW'(va) : NW'(vb);
  assign match    = (nb_q == srch_to);
  assign srch_end = (k >= kend);
  assign ba_total = total + EW'(need_ab);

  always_comb begin
    logic [31:0] raw;
    raw = 32'(hi_b) + 32'(need_ab && (vb > va));
    ba_pos = (raw > 32'(ba_total)) ? ba_total : EW'(raw);
  end

  always_comb begin
    in_status = cqg_pkg::ST_OK;
    unique case (command)
      cqg_pkg::CMD_LOAD_PART: begin
        if (32'(vertex_a) >= MAX_REF_VERTICES) in_status = cqg_pkg::ST_RANGE;
      end
      cqg_pkg::CMD_ADD_REF:       if (bad_ref) in_status = cqg_pkg::ST_RANGE;
      cqg_pkg::CMD_READ_OFFSET:   if (bad_off) in_status = cqg_pkg::ST_RANGE;
      cqg_pkg::CMD_READ_NEIGHBOR: if (bad_nb) in_status = cqg_pkg::ST_RANGE;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cqg_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (command)
            cqg_pkg::CMD_ADD_EDGE:      state_next = cqg_pkg::S_CHECK;
            cqg_pkg::CMD_ADD_REF:       state_next = bad_ref ? cqg_pkg::S_DONE : cqg_pkg::S_PREAD;
            cqg_pkg::CMD_READ_OFFSET:   state_next = bad_off ? cqg_pkg::S_DONE : cqg_pkg::S_ROT_READ;
            cqg_pkg::CMD_READ_NEIGHBOR: state_next = bad_nb ? cqg_pkg::S_DONE : cqg_pkg::S_NREAD;
            default:                    state_next = cqg_pkg::S_DONE;
          endcase
        end
      end
      cqg_pkg::S_PREAD: state_next = (pa_q == pb_q) ? cqg_pkg::S_DONE : cqg_pkg::S_CHECK;
      cqg_pkg::S_CHECK: state_next = bad_ab ? cqg_pkg::S_DONE : cqg_pkg::S_ROT_READ;
      cqg_pkg::S_ROT_READ: begin
        if (rot_last) begin
          state_next = (cmd == cqg_pkg::CMD_READ_OFFSET) ? cqg_pkg::S_DONE : cqg_pkg::S_SRCH_INIT;
        end
      end
      cqg_pkg::S_SRCH_INIT: state_next = cqg_pkg::S_SRCH_SET;
      cqg_pkg::S_SRCH_SET: begin
        if (srch_end) begin
          state_next = (!pass_ba && va != vb) ? cqg_pkg::S_SRCH_INIT : cqg_pkg::S_DECIDE;
        end else begin
          state_next = cqg_pkg::S_SRCH_CMP;
        end
      end
      cqg_pkg::S_SRCH_CMP: begin
        if (match) begin
          state_next = (!pass_ba && va != vb) ? cqg_pkg::S_SRCH_INIT : cqg_pkg::S_DECIDE;
        end else begin
          state_next = cqg_pkg::S_SRCH_SET;
        end
      end
      cqg_pkg::S_DECIDE: state_next = (fits && need != 2'd0) ? cqg_pkg::S_SHIFT_RD : cqg_pkg::S_DONE;
      cqg_pkg::S_SHIFT_RD: state_next = (k > ins_pos) ? cqg_pkg::S_SHIFT_WR : cqg_pkg::S_PLACE;
      cqg_pkg::S_SHIFT_WR: state_next = cqg_pkg::S_SHIFT_RD;
      cqg_pkg::S_PLACE: state_next = (!ins_ba && need_ba) ? cqg_pkg::S_SHIFT_RD : cqg_pkg::S_ROT_INC;
      cqg_pkg::S_ROT_INC: state_next = rot_last ? cqg_pkg::S_DONE : cqg_pkg::S_ROT_INC;
      cqg_pkg::S_NREAD: state_next = cqg_pkg::S_DONE;
      cqg_pkg::S_DONE: state_next = out_load ? cqg_pkg::S_IDLE : cqg_pkg::S_DONE;
      default: state_next = cqg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ring.clear  = cfg_we || (in_acc && command == cqg_pkg::CMD_CLEAR);
    ring.rotate = (state == cqg_pkg::S_ROT_READ) || (state == cqg_pkg::S_ROT_INC);
    ring.inc    = 2'd0;
    if (state == cqg_pkg::S_ROT_INC && 32'(idx) <= 32'(np)) begin
      ring.inc = {1'b0, need_ab && (32'(idx) > 32'(va))}
               + {1'b0, need_ba && (32'(idx) > 32'(vb))};
    end
    nb_raddr = AW'(k);
    nb_we    = 1'b0;
    nb_waddr = AW'(k);
    nb_wdata = nb_q;
    unique case (state)
      cqg_pkg::S_IDLE:     nb_raddr = AW'(read_index);
      cqg_pkg::S_SHIFT_RD: nb_raddr = AW'(k - EW'(1));
      cqg_pkg::S_SHIFT_WR: nb_we = 1'b1;
      cqg_pkg::S_PLACE: begin
        nb_we    = 1'b1;
        nb_waddr = AW'(ins_pos);
        nb_wdata = ins_ba ? NW'(va) : NW'(vb);
      end
      default: ;
    endcase
  end

  cqg_offset_ring #(.CELLS(CELLS), .W(EW)) u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring),
    .tap  (tap)
  );

  always_ff @(posedge clk) begin
    nb_q <= nb_mem[nb_raddr];
    if (nb_we) begin
      nb_mem[nb_waddr] <= nb_wdata;
    end
  end

  always_ff @(posedge clk) begin
    pa_q <= pt_mem[RW'(vertex_a)];
    pb_q <= pt_mem[RW'(vertex_b)];
    if (in_acc && command == cqg_pkg::CMD_LOAD_PART && 32'(vertex_a) < MAX_REF_VERTICES) begin
      pt_mem[RW'(vertex_a)] <= part_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cqg_pkg::S_IDLE;
      num_parts <= cqg_pkg::CFG_W'(MAX_PARTS);
      total     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_parts <= cfg_wdata;
        total     <= '0;
      end else if (in_acc && command == cqg_pkg::CMD_CLEAR) begin
        total <= '0;
      end else if (state == cqg_pkg::S_PLACE) begin
        total <= total + EW'(1);
      end
      if (ring.rotate) begin
        idx <= rot_last ? '0 : idx + PW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd        <= command;
      va         <= vertex_a;
      vb         <= vertex_b;
      res_status <= in_status;
      res_added  <= '0;
      res_read   <= '0;
    end
    unique case (state)
      cqg_pkg::S_PREAD: begin
        va <= cqg_pkg::VERTEX_W'(pa_q);
        vb <= cqg_pkg::VERTEX_W'(pb_q);
      end
      cqg_pkg::S_CHECK: begin
        found_ab <= 1'b0;
        found_ba <= 1'b0;
        pass_ba  <= 1'b0;
        if (bad_ab) res_status <= cqg_pkg::ST_RANGE;
      end
      cqg_pkg::S_ROT_READ: begin
        if (32'(idx) == 32'(va))      lo_a <= tap;
        if (32'(idx) == 32'(va) + 1)  hi_a <= tap;
        if (32'(idx) == 32'(vb))      lo_b <= tap;
        if (32'(idx) == 32'(vb) + 1)  hi_b <= tap;
        if (cmd == cqg_pkg::CMD_READ_OFFSET && 32'(idx) == 32'(ri)) begin
          res_read <= cqg_pkg::COUNT_W'(tap);
        end
      end
      cqg_pkg::S_SRCH_INIT: begin
        if (!pass_ba) begin
          k    <= lo_a;
          kend <= (hi_a > total) ? total : hi_a;
        end else begin
          k    <= lo_b;
          kend <= (hi_b > total) ? total : hi_b;
        end
      end
      cqg_pkg::S_SRCH_SET: begin
        if (srch_end) pass_ba <= 1'b1;
      end
      cqg_pkg::S_SRCH_CMP: begin
        k <= k + EW'(1);
        if (match) begin
          pass_ba <= 1'b1;
          if (pass_ba) found_ba <= 1'b1;
          else         found_ab <= 1'b1;
        end
      end
      cqg_pkg::S_DECIDE: begin
        if (!fits) begin
          res_status <= cqg_pkg::ST_FULL;
        end else begin
          res_added <= need;
          ins_ba    <= !need_ab;
          if (need_ab) begin
            k       <= total;
            ins_pos <= (hi_a > total) ? total : hi_a;
          end else begin
            k       <= ba_total;
            ins_pos <= ba_pos;
          end
        end
      end
      cqg_pkg::S_SHIFT_WR: k <= k - EW'(1);
      cqg_pkg::S_PLACE: begin
        if (!ins_ba && need_ba) begin
          ins_ba  <= 1'b1;
          k       <= ba_total;
          ins_pos <= ba_pos;
        end
      end
      cqg_pkg::S_NREAD: res_read <= cqg_pkg::COUNT_W'(nb_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ri <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status           <= res_status;
      directions_added <= res_added;
      edge_entries     <= cqg_pkg::COUNT_W'(total);
      read_value       <= res_read;
    end
  end

endmodule

@@ hw/rtl/cqg_checker.sv @@
module cqg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [1:0]  directions_added,
  input logic [11:0] edge_entries,
  input logic [11:0] read_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(edge_entries))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  a_added_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && directions_added != 2'd0 |-> status == 2'd0 && directions_added != 2'd3)
    else $error("entries added with error status");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> directions_added == 2'd0 && read_value == 12'd0)
    else $error("error result carries data");

endmodule

bind csr_quotient_graph_builder_top cqg_checker u_cqg_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [cqg_pkg::STATUS_W-1:0] status;
    logic [cqg_pkg::ADDED_W-1:0]  added;
    logic [cqg_pkg::COUNT_W-1:0]  entries;
    logic [cqg_pkg::COUNT_W-1:0]  value;
  } graph_result_t;

  class graph_scoreboard;
    int offs[257];
    int nbr[2048];
    int part[1024];
    int total;
    int nparts;
    int errors;
    graph_result_t pending[$];

    function void set_parts(int v);
      nparts = v;
      foreach (offs[i]) offs[i] = 0;
      total = 0;
    endfunction

    function int active();
      if (nparts == 0) return 1;
      if (nparts > 256) return 256;
      return nparts;
    endfunction

    function bit has_entry(int from, int to);
      int lo;
      int hi;
      lo = offs[from];
      hi = offs[from + 1];
      if (hi > total) hi = total;
      for (int k = lo; k < hi; k++) if (nbr[k] == to) return 1;
      return 0;
    endfunction

    function void insert_entry(int from, int to);
      int pos;
      pos = offs[from + 1];
      if (pos > total) pos = total;
      for (int k = total; k > pos; k--) nbr[k] = nbr[k - 1];
      nbr[pos] = to;
      for (int k = from + 1; k <= active(); k++) offs[k] += 1;
      total += 1;
    endfunction

    function int add_pair(int a, int b, output int added);
      bit need_ab;
      bit need_ba;
      int need;
      added = 0;
      if (a >= active() || b >= active()) return int'(cqg_pkg::ST_RANGE);
      need_ab = !has_entry(a, b);
      need_ba = (a != b) && !has_entry(b, a);
      need = int'(need_ab) + int'(need_ba);
      if (total + need > 2048) return int'(cqg_pkg::ST_FULL);
      if (need_ab) insert_entry(a, b);
      if (need_ba) insert_entry(b, a);
      added = need;
      return int'(cqg_pkg::ST_OK);
    endfunction

    function void note(int cmd, int a, int b, int p, int r);
      int st;
      int ad;
      int rv;
      graph_result_t res;
      st = int'(cqg_pkg::ST_OK);
      ad = 0;
      rv = 0;
      case (cmd)
        cqg_pkg::CMD_ADD_EDGE: st = add_pair(a, b, ad);
        cqg_pkg::CMD_LOAD_PART: part[a] = p;
        cqg_pkg::CMD_ADD_REF: if (part[a] != part[b]) st = add_pair(part[a], part[b], ad);
        cqg_pkg::CMD_READ_OFFSET: begin
          if (r > active()) st = int'(cqg_pkg::ST_RANGE);
          else rv = offs[r];
        end
        cqg_pkg::CMD_READ_NEIGHBOR: begin
          if (r >= total) st = int'(cqg_pkg::ST_RANGE);
          else rv = nbr[r];
        end
        cqg_pkg::CMD_CLEAR: begin
          foreach (offs[i]) offs[i] = 0;
          total = 0;
        end
        default: ;
      endcase
      res.status = cqg_pkg::STATUS_W'(st);
      res.added = cqg_pkg::ADDED_W'(ad);
      res.entries = cqg_pkg::COUNT_W'(total);
      res.value = cqg_pkg::COUNT_W'(rv);
      pending.push_back(res);
    endfunction

    function void check(graph_result_t got);
      graph_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.added !== want.added) begin
        $display("%0t: directions_added expected %0d actual %0d", $time, want.added,
                 got.added);
        errors++;
      end
      if (got.entries !== want.entries) begin
        $display("%0t: edge_entries expected %0d actual %0d", $time, want.entries,
                 got.entries);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: read_value expected %0d actual %0d", $time, want.value, got.value);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 0;
  logic                         rst = 1;
  logic                         cfg_we = 0;
  logic [cqg_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 0;
  logic                         in_stall;
  logic [cqg_pkg::CMD_W-1:0]    command = '0;
  logic [cqg_pkg::VERTEX_W-1:0] vertex_a = '0;
  logic [cqg_pkg::VERTEX_W-1:0] vertex_b = '0;
  logic [cqg_pkg::PART_W-1:0]   part_value = '0;
  logic [cqg_pkg::INDEX_W-1:0]  read_index = '0;
  logic                         out_valid;
  logic                         out_stall = 0;
  logic [cqg_pkg::STATUS_W-1:0] status;
  logic [cqg_pkg::ADDED_W-1:0]  directions_added;
  logic [cqg_pkg::COUNT_W-1:0]  edge_entries;
  logic [cqg_pkg::COUNT_W-1:0]  read_value;

  graph_scoreboard sb = new();
  bit noisy = 1;
  int out_hold = 0;
  int loaded_q[$];

  csr_quotient_graph_builder_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .part_value(part_value),
    .read_index(read_index), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .directions_added(directions_added),
    .edge_entries(edge_entries), .read_value(read_value)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (noisy && out_hold == 0 && $urandom_range(0, 3) == 0) out_hold = $urandom_range(1, 6);
    out_stall <= (out_hold > 0);
    if (out_hold > 0) out_hold--;
  end

  always @(posedge clk) begin
    graph_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status = status;
      got.added = directions_added;
      got.entries = edge_entries;
      got.value = read_value;
      sb.check(got);
    end
  end

  task automatic send(int cmd, int a, int b, int p, int r);
    @(negedge clk);
    if (noisy && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    command = cqg_pkg::CMD_W'(cmd);
    vertex_a = cqg_pkg::VERTEX_W'(a);
    vertex_b = cqg_pkg::VERTEX_W'(b);
    part_value = cqg_pkg::PART_W'(p);
    read_index = cqg_pkg::INDEX_W'(r);
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note(cmd, a, b, p, r);
    if (cmd == cqg_pkg::CMD_LOAD_PART) loaded_q.push_back(a);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_parts(int v);
    drain();
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = cqg_pkg::CFG_W'(v);
    sb.set_parts(v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic int pick_vertex(int np);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, np - 1);
  endfunction

  task automatic random_request();
    int np;
    int sel;
    int p;
    np = sb.active();
    sel = $urandom_range(0, 99);
    if (sel < 40 || sel >= 95) begin
      send(cqg_pkg::CMD_ADD_EDGE, pick_vertex(np), pick_vertex(np), $urandom_range(0, 255),
           $urandom_range(0, 2047));
    end else if (sel < 50 || (sel < 65 && loaded_q.size() == 0)) begin
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, np - 1);
      send(cqg_pkg::CMD_LOAD_PART, $urandom_range(0, 1023), $urandom_range(0, 1023), p,
           $urandom_range(0, 2047));
    end else if (sel < 65) begin
      send(cqg_pkg::CMD_ADD_REF, loaded_q[$urandom_range(0, loaded_q.size() - 1)],
           loaded_q[$urandom_range(0, loaded_q.size() - 1)], $urandom_range(0, 255),
           $urandom_range(0, 2047));
    end else if (sel < 75) begin
      send(cqg_pkg::CMD_READ_OFFSET, $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 255),
           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, np + 1));
    end else if (sel < 88) begin
      send(cqg_pkg::CMD_READ_NEIGHBOR, $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 255),
           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                       : $urandom_range(0, sb.total));
    end else if (sel < 92) begin
      send(cqg_pkg::CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 255), $urandom_range(0, 2047));
    end else begin
      send($urandom_range(6, 7), $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 255), $urandom_range(0, 2047));
    end
  endtask

  initial begin
    int settings[7] = '{0, 1, 300, 511, 8, 17, 256};
    sb.errors = 0;
    sb.set_parts(256);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(cqg_pkg::CMD_READ_OFFSET, 0, 0, 0, 0);
    send(cqg_pkg::CMD_READ_OFFSET, 0, 0, 0, 256);
    send(cqg_pkg::CMD_READ_OFFSET, 0, 0, 0, 257);
    send(cqg_pkg::CMD_READ_NEIGHBOR, 0, 0, 0, 0);
    send(cqg_pkg::CMD_ADD_EDGE, 0, 255, 0, 0);
    send(cqg_pkg::CMD_ADD_EDGE, 255, 0, 0, 0);
    send(cqg_pkg::CMD_ADD_EDGE, 3, 3, 0, 0);
    send(cqg_pkg::CMD_ADD_EDGE, 3, 3, 0, 0);
    send(cqg_pkg::CMD_ADD_EDGE, 1023, 0, 0, 0);
    send(cqg_pkg::CMD_ADD_EDGE, 0, 256, 0, 0);
    send(cqg_pkg::CMD_LOAD_PART, 0, 1023, 5, 2047);
    send(cqg_pkg::CMD_LOAD_PART, 1023, 0, 255, 0);
    send(cqg_pkg::CMD_LOAD_PART, 7, 0, 5, 0);
    send(cqg_pkg::CMD_LOAD_PART, 8, 0, 9, 0);
    send(cqg_pkg::CMD_ADD_REF, 0, 7, 0, 0);
    send(cqg_pkg::CMD_ADD_REF, 0, 8, 0, 0);
    send(cqg_pkg::CMD_ADD_REF, 1023, 0, 0, 0);
    send(cqg_pkg::CMD_READ_NEIGHBOR, 0, 0, 0, 0);
    send(cqg_pkg::CMD_READ_NEIGHBOR, 0, 0, 0, 7);
    send(cqg_pkg::CMD_READ_OFFSET, 0, 0, 0, 5);
    send(6, 1023, 1023, 255, 2047);
    send(7, 0, 0, 0, 0);
    send(cqg_pkg::CMD_CLEAR, 0, 0, 0, 0);
    send(cqg_pkg::CMD_READ_OFFSET, 0, 0, 0, 256);

    foreach (settings[s]) begin
      write_parts(settings[s]);
      repeat (36) random_request();
    end

    // no idling from here on
    noisy = 0;
    repeat (14) random_request();
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd600_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cqg_pkg.sv
hw/rtl/cqg_cell.sv
hw/rtl/cqg_offset_ring.sv
hw/rtl/csr_quotient_graph_builder_top.sv
hw/rtl/cqg_checker.sv
tb/sv/testbench.sv
